@@ rtl/core/knn_pkg.sv @@
// Shared types and constants for the k-nearest-neighbor top-k selector.
// No dependencies; imported by the top-level selector and its testbench.
package knn_pkg;

    localparam int MAX_K  = 128;
    localparam int DIST_W = 48;
    localparam int IDX_W  = 32;
    localparam int VAL_W  = 16;
    localparam int CNT_W  = 8;
    localparam int RANK_W = 7;
    localparam int MAG_W  = VAL_W + 1;
    localparam int SQ_W   = 2 * MAG_W;

    localparam logic [1:0] REQ_ELEM  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [CNT_W-1:0] K_RESET = 8'd128;

    typedef struct packed {
        logic [DIST_W-1:0] sqdist;
        logic [IDX_W-1:0]  idx;
    } entry_t;

    localparam int ENTRY_W = DIST_W + IDX_W;

    // true if (d1,i1) orders strictly ahead of (d2,i2)
    function automatic logic entry_before(input entry_t a, input entry_t b);
        return (a.sqdist < b.sqdist) || ((a.sqdist == b.sqdist) && (a.idx < b.idx));
    endfunction

endpackage

@@ rtl/core/knn_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module knn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/knn_topk_distance_select.sv @@
// Brute-force k-nearest-neighbor top-k selector. Element words stream one query and one base
// element each; the squared difference is summed into a saturating 48-bit accumulator, and on
// the last element the (distance, index) pair is offered to a list sorted by distance then
// index, held in one RAM of MAX_K entries. An element word goes through a square step, then an
// accumulate step; a last element adds an insertion that moves entries one at a time through
// the RAM's single read port and single write port. A read word waits until the output register
// is free; a clear completes in the idle state.
// Depends on knn_pkg and knn_ram.
module knn_topk_distance_select (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [knn_pkg::CNT_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         req_type,
    input  logic signed [knn_pkg::VAL_W-1:0]   query_value,
    input  logic signed [knn_pkg::VAL_W-1:0]   base_value,
    input  logic                               last_element,
    input  logic [knn_pkg::IDX_W-1:0]          point_index,
    input  logic [knn_pkg::RANK_W-1:0]         read_rank,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [knn_pkg::DIST_W-1:0]         result_distance,
    output logic [knn_pkg::IDX_W-1:0]          result_index,
    output logic                               entry_valid,
    output logic [knn_pkg::CNT_W-1:0]          entries_held
);

    import knn_pkg::*;

    localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SQ      = 3'd1;
    localparam logic [2:0] ST_ACC     = 3'd2;
    localparam logic [2:0] ST_OFFER   = 3'd3;
    localparam logic [2:0] ST_OFF_CHK = 3'd4;
    localparam logic [2:0] ST_SH_RD   = 3'd5;
    localparam logic [2:0] ST_SH_CHK  = 3'd6;
    localparam logic [2:0] ST_RD_OUT  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  k_limit_reg, k_limit_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DIST_W-1:0] acc_reg, acc_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic              last_reg, last_next;
    entry_t            cand_reg, cand_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              rank_ok_reg, rank_ok_next;
    logic              out_valid_reg, out_valid_next;
    entry_t            out_entry_reg, out_entry_next;
    logic              out_ok_reg, out_ok_next;
    logic [CNT_W-1:0]  out_held_reg, out_held_next;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    entry_t            ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0] ram_rbits;

    logic [CNT_W-1:0]  keff;
    logic [CNT_W-1:0]  cfg_keff;
    logic signed [MAG_W-1:0] diff;
    logic [DIST_W:0]   acc_sum;
    logic [DIST_W-1:0] acc_sat;
    logic              out_free;

    // clamp a k value into 1..MAX_K
    function automatic logic [CNT_W-1:0] clamp_k(input logic [CNT_W-1:0] k);
        logic [CNT_W-1:0] r;
        r = (k == '0) ? CNT_W'(1) : k;
        if (MAX_K < (1 << CNT_W) && r > CNT_W'(MAX_K))
        begin
            r = CNT_W'(MAX_K);
        end
        return r;
    endfunction

    knn_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_K)
    ) u_list_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    assign ram_rdata = entry_t'(ram_rbits);

    // derived values
    assign keff     = clamp_k(k_limit_reg);
    assign cfg_keff = clamp_k(cfg_data);
    assign diff     = MAG_W'(query_value) - MAG_W'(base_value);
    assign acc_sum  = {1'b0, acc_reg} + (DIST_W + 1)'(sq_reg);
    assign acc_sat  = acc_sum[DIST_W] ? {DIST_W{1'b1}} : acc_sum[DIST_W-1:0];
    assign out_free = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        k_limit_next   = k_limit_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        sq_next        = sq_reg;
        last_next      = last_reg;
        cand_next      = cand_reg;
        pos_next       = pos_reg;
        rank_ok_next   = rank_ok_reg;
        out_entry_next = out_entry_reg;
        out_ok_next    = out_ok_reg;
        out_held_next  = out_held_reg;
        out_valid_next = out_valid_reg && out_stall;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = cand_reg;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // apply configuration, trimming the list to the new k
                if (cfg_valid)
                begin
                    k_limit_next = cfg_data;
                    if (count_reg > cfg_keff)
                    begin
                        count_next = cfg_keff;
                    end
                end
                if (in_valid)
                begin
                    priority if (req_type == REQ_ELEM)
                    begin
                        mag_next  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
                        last_next = last_element;
                        cand_next.idx = point_index;
                        state_next = ST_SQ;
                    end
                    else if (req_type == REQ_READ)
                    begin
                        rank_ok_next = (CNT_W'(read_rank) < count_reg);
                        ram_re       = 1'b1;
                        ram_raddr    = AW'(read_rank);
                        state_next   = ST_RD_OUT;
                    end
                    else if (req_type == REQ_CLEAR)
                    begin
                        count_next = '0;
                        acc_next   = '0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SQ:
            begin
                sq_next    = mag_reg * mag_reg;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (last_reg)
                begin
                    cand_next.sqdist = acc_sat;
                    acc_next         = '0;
                    state_next       = ST_OFFER;
                end
                else
                begin
                    acc_next   = acc_sat;
                    state_next = ST_IDLE;
                end
            end
            ST_OFFER:
            begin
                // room left: insert; full: compare with the worst entry
                if (count_reg < keff)
                begin
                    pos_next   = count_reg;
                    state_next = ST_SH_RD;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(count_reg - CNT_W'(1));
                    state_next = ST_OFF_CHK;
                end
            end
            ST_OFF_CHK:
            begin
                // drop the worst entry only if strictly farther
                if (ram_rdata.sqdist > cand_reg.sqdist)
                begin
                    count_next = count_reg - CNT_W'(1);
                    pos_next   = count_reg - CNT_W'(1);
                    state_next = ST_SH_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SH_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = cand_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(pos_reg - CNT_W'(1));
                    state_next = ST_SH_CHK;
                end
            end
            ST_SH_CHK:
            begin
                // move the neighbor down one slot, or drop the candidate in place
                ram_we    = 1'b1;
                ram_waddr = AW'(pos_reg);
                if (entry_before(cand_reg, ram_rdata))
                begin
                    ram_wdata  = ram_rdata;
                    pos_next   = pos_reg - CNT_W'(1);
                    state_next = ST_SH_RD;
                end
                else
                begin
                    ram_wdata  = cand_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_RD_OUT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_ok_next           = rank_ok_reg;
                    out_held_next         = count_reg;
                    out_entry_next.sqdist = rank_ok_reg ? ram_rdata.sqdist : '0;
                    out_entry_next.idx    = rank_ok_reg ? ram_rdata.idx : '0;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_limit_reg   <= K_RESET;
            count_reg     <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_limit_reg   <= k_limit_next;
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        sq_reg        <= sq_next;
        last_reg      <= last_next;
        cand_reg      <= cand_next;
        pos_reg       <= pos_next;
        rank_ok_reg   <= rank_ok_next;
        out_entry_reg <= out_entry_next;
        out_ok_reg    <= out_ok_next;
        out_held_reg  <= out_held_next;
    end

    assign out_valid       = out_valid_reg;
    assign result_distance = out_entry_reg.sqdist;
    assign result_index    = out_entry_reg.idx;
    assign entry_valid     = out_ok_reg;
    assign entries_held    = out_held_reg;

endmodule

@@ tb/knn_topk_distance_select_tb.sv @@
// Self-checking testbench for the brute-force k-nearest-neighbor top-k selector.
// Depends on knn_pkg and the knn_topk_distance_select RTL; needs no files or arguments.
module knn_topk_distance_select_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import knn_pkg::*;

    localparam int LIST_DEPTH = MAX_K;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam longint unsigned DIST_SAT = (64'd1 << DIST_W) - 1;
    localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 40;

    typedef struct {
        logic [DIST_W-1:0] sqdist;
        logic [IDX_W-1:0]  idx;
        logic              valid;
        logic [CNT_W-1:0]  held;
    } read_word_t;

    typedef struct {
        logic [1:0]        req;
        logic [VAL_W-1:0]  q;
        logic [VAL_W-1:0]  b;
        logic              last;
        logic [IDX_W-1:0]  idx;
        logic [RANK_W-1:0] rank;
        bit                typed;
        read_word_t        want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] req_type = REQ_UNUSED;
    logic signed [VAL_W-1:0] query_value = '0;
    logic signed [VAL_W-1:0] base_value = '0;
    logic last_element = 1'b0;
    logic [IDX_W-1:0] point_index = '0;
    logic [RANK_W-1:0] read_rank = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic [DIST_W-1:0] result_distance;
    logic [IDX_W-1:0] result_index;
    logic entry_valid;
    logic [CNT_W-1:0] entries_held;

    // predicted block state
    longint unsigned model_acc;
    logic [DIST_W-1:0] model_dist [LIST_DEPTH];
    logic [IDX_W-1:0]  model_idx [LIST_DEPTH];
    int unsigned model_held;
    int unsigned model_k;

    read_word_t pending_reads [$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_off = 1'b0;

    knn_topk_distance_select dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .query_value(query_value), .base_value(base_value),
        .last_element(last_element), .point_index(point_index), .read_rank(read_rank),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_distance(result_distance), .result_index(result_index),
        .entry_valid(entry_valid), .entries_held(entries_held)
    );

    always #2 clk = ~clk;

    // Run limit, far above the slowest correct run
    initial
    begin
        #40_000_000;
        $display("[knn_topk_distance_select] ERROR");
        $finish;
    end

    function automatic int unsigned clamp_k(int unsigned k);
        if (k == 0) return 1;
        if (k > LIST_DEPTH) return LIST_DEPTH;
        return k;
    endfunction

    function automatic bit ranks_ahead(logic [DIST_W-1:0] d1, logic [IDX_W-1:0] i1,
                                       logic [DIST_W-1:0] d2, logic [IDX_W-1:0] i2);
        return (d1 < d2) || (d1 == d2 && i1 < i2);
    endfunction

    // Insert a candidate into the predicted sorted list
    task automatic place_candidate(logic [DIST_W-1:0] d, logic [IDX_W-1:0] id);
        int unsigned pos;
        pos = model_held;
        while (pos > 0 && ranks_ahead(d, id, model_dist[pos-1], model_idx[pos-1]))
        begin
            model_dist[pos] = model_dist[pos-1];
            model_idx[pos] = model_idx[pos-1];
            pos--;
        end
        model_dist[pos] = d;
        model_idx[pos] = id;
        model_held++;
    endtask

    // Advance the predicted state by one accepted word; queue a read result
    task automatic predict_word(logic [1:0] req, logic [VAL_W-1:0] q, logic [VAL_W-1:0] b,
                                logic last, logic [IDX_W-1:0] id, logic [RANK_W-1:0] rank,
                                bit typed, read_word_t want);
        longint signed diff;
        longint unsigned sq;
        read_word_t r;
        if (req == REQ_ELEM)
        begin
            diff = longint'($signed(q)) - longint'($signed(b));
            if (diff < 0) diff = -diff;
            sq = longint'(diff) * longint'(diff);
            if (sq > DIST_SAT - model_acc) model_acc = DIST_SAT;
            else model_acc += sq;
            if (last)
            begin
                if (model_held < clamp_k(model_k))
                    place_candidate(model_acc[DIST_W-1:0], id);
                else if (model_held > 0 && model_dist[model_held-1] > model_acc)
                begin
                    model_held--;
                    place_candidate(model_acc[DIST_W-1:0], id);
                end
                model_acc = 0;
            end
        end
        else if (req == REQ_READ)
        begin
            r.valid = rank < model_held;
            r.sqdist = r.valid ? model_dist[rank] : '0;
            r.idx = r.valid ? model_idx[rank] : '0;
            r.held = model_held[CNT_W-1:0];
            pending_reads.insert(pending_reads.size(), typed ? want : r);
        end
        else if (req == REQ_CLEAR)
        begin
            model_held = 0;
            model_acc = 0;
        end
    endtask

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Check each accepted read word against the oldest expectation
    always @(posedge clk)
    begin
        read_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reads.size() == 0)
                report_mismatch("unexpected word", result_index, 0);
            else
            begin
                w = pending_reads.pop_front();
                if (result_distance !== w.sqdist)
                    report_mismatch("distance", result_distance, w.sqdist);
                if (result_index !== w.idx) report_mismatch("index", result_index, w.idx);
                if (entry_valid !== w.valid) report_mismatch("entry_valid", entry_valid, w.valid);
                if (entries_held !== w.held) report_mismatch("entries_held", entries_held, w.held);
            end
        end
    end

    // Drive the output stall: random, or held during a hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b1;
        else
            out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // Offer one word, with random idle cycles ahead of it
    task automatic send_word(logic [1:0] req, logic [VAL_W-1:0] q, logic [VAL_W-1:0] b,
                             logic last, logic [IDX_W-1:0] id, logic [RANK_W-1:0] rank,
                             bit typed = 0, read_word_t want = '{default: '0});
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        query_value <= q;
        base_value <= b;
        last_element <= last;
        point_index <= id;
        read_rank <= rank;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_word(req, q, b, last, id, rank, typed, want);
    endtask

    // Hold the sender until every read result has arrived and the block settles
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_k(logic [CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        model_k = value;
        if (model_held > clamp_k(model_k)) model_held = clamp_k(model_k);
    endtask

    task automatic hold_receiver(int cycles);
        fork
            begin
                hold_off <= 1'b1;
                repeat (cycles) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
    endtask

    function automatic logic [VAL_W-1:0] pick_value(bit tiny);
        if (tiny) return VAL_W'($signed($urandom_range(2)) - 1);
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Random mix of vectors, reads, clears and unused codes
    task automatic random_phase(int words, bit with_hold);
        int sent;
        int pick;
        int len;
        bit tiny;
        bit hold_done;
        bit pause_done;
        logic [IDX_W-1:0] id;
        sent = 0;
        hold_done = 0;
        pause_done = 0;
        while (sent < words)
        begin
            if (with_hold && !hold_done && sent >= words / 3)
            begin
                hold_receiver(700);
                hold_done = 1;
            end
            if (!pause_done && sent >= words / 2)
            begin
                pause_done = 1;
                if ($urandom_range(1)) drain();
            end
            pick = $urandom_range(99);
            if (pick < 68)
            begin
                len = $urandom_range(1, 4);
                tiny = $urandom_range(2) == 0;
                id = tiny ? IDX_W'($urandom_range(15)) : IDX_W'($urandom);
                for (int j = 0; j < len; j++)
                    send_word(REQ_ELEM, pick_value(tiny), pick_value(tiny), j == len - 1,
                              (j == len - 1) ? id : IDX_W'($urandom), RANK_W'($urandom));
                sent += len;
            end
            else if (pick < 96)
            begin
                send_word(REQ_READ, VAL_W'($urandom), VAL_W'($urandom), 1'($urandom), IDX_W'($urandom),
                          ($urandom_range(3) == 0) ? RANK_W'($urandom)
                              : RANK_W'($urandom_range(0, (model_held > 0) ? model_held : 0)));
                sent++;
            end
            else if (pick < 98)
            begin
                send_word(REQ_CLEAR, VAL_W'($urandom), VAL_W'($urandom), 1'($urandom),
                          IDX_W'($urandom), RANK_W'($urandom));
                sent++;
            end
            else
                send_word(REQ_UNUSED, VAL_W'($urandom), VAL_W'($urandom), 1'($urandom),
                          IDX_W'($urandom), RANK_W'($urandom));
        end
    endtask

    stim_row_t directed [] = '{
        '{REQ_READ,  16'h0000, 16'h0000, 1'b0, 32'h0,        7'd0,   1, '{48'd0, 32'd0, 1'b0, 8'd0}},
        '{REQ_ELEM,  16'h8000, 16'h7FFF, 1'b1, 32'h5,        7'd0,   0, '{default: '0}},
        '{REQ_READ,  16'h0000, 16'h0000, 1'b0, 32'h0,        7'd0,   1,
          '{48'd4294836225, 32'd5, 1'b1, 8'd1}},
        '{REQ_ELEM,  16'h7FFF, 16'h8000, 1'b0, 32'h0,        7'd0,   0, '{default: '0}},
        '{REQ_ELEM,  16'h0000, 16'h0000, 1'b1, 32'hFFFFFFFF, 7'd0,   0, '{default: '0}},
        '{REQ_READ,  16'h0000, 16'h0000, 1'b0, 32'h0,        7'd1,   0, '{default: '0}},
        '{REQ_READ,  16'h0000, 16'h0000, 1'b0, 32'h0,        7'd127, 1, '{48'd0, 32'd0, 1'b0, 8'd2}},
        '{REQ_ELEM,  16'h0064, 16'h0064, 1'b1, 32'h0,        7'd0,   0, '{default: '0}},
        '{REQ_READ,  16'h0000, 16'h0000, 1'b0, 32'h0,        7'd0,   1, '{48'd0, 32'd0, 1'b1, 8'd3}},
        '{REQ_UNUSED,16'h7FFF, 16'h8000, 1'b1, 32'h1234,     7'd5,   0, '{default: '0}},
        '{REQ_READ,  16'h0000, 16'h0000, 1'b0, 32'h0,        7'd2,   0, '{default: '0}},
        '{REQ_ELEM,  16'h0001, 16'hFFFF, 1'b1, 32'h9,        7'd0,   0, '{default: '0}},
        '{REQ_ELEM,  16'hFFFF, 16'h0001, 1'b1, 32'h8,        7'd0,   0, '{default: '0}},
        '{REQ_READ,  16'h0000, 16'h0000, 1'b0, 32'h0,        7'd1,   0, '{default: '0}},
        '{REQ_READ,  16'h0000, 16'h0000, 1'b0, 32'h0,        7'd2,   0, '{default: '0}},
        '{REQ_CLEAR, 16'h0000, 16'h0000, 1'b0, 32'h0,        7'd0,   0, '{default: '0}},
        '{REQ_READ,  16'h0000, 16'h0000, 1'b0, 32'h0,        7'd0,   1, '{48'd0, 32'd0, 1'b0, 8'd0}},
        '{REQ_ELEM,  16'h1000, 16'h0000, 1'b0, 32'h0,        7'd0,   0, '{default: '0}},
        '{REQ_ELEM,  16'h0000, 16'hF000, 1'b1, 32'h7,        7'd0,   0, '{default: '0}},
        '{REQ_READ,  16'h0000, 16'h0000, 1'b0, 32'h0,        7'd0,   0, '{default: '0}}
    };

    int idle_plan [4] = '{0, 62, 0, 25};
    int stall_plan [4] = '{0, 0, 62, 25};
    logic [CNT_W-1:0] k_plan [8] = '{8'd128, 8'd1, 8'd0, 8'd255, 8'd3, 8'd128, 8'd7, 8'd2};

    initial
    begin
        model_acc = 0;
        model_held = 0;
        model_k = K_RESET;
        foreach (model_dist[i])
        begin
            model_dist[i] = '0;
            model_idx[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table at full rate
        foreach (directed[i])
            send_word(directed[i].req, directed[i].q, directed[i].b, directed[i].last,
                      directed[i].idx, directed[i].rank, directed[i].typed, directed[i].want);
        drain();

        // Push one long vector of extreme elements
        for (int j = 0; j < 64; j++)
            send_word(REQ_ELEM, 16'h8000, 16'h7FFF, j == 63, 32'hA5A5A5A5, 7'd0);
        send_word(REQ_READ, 16'h0, 16'h0, 1'b0, 32'h0, 7'd0);
        send_word(REQ_READ, 16'h0, 16'h0, 1'b0, 32'h0, 7'd127);
        drain();

        // Random phases across list sizes and idle patterns
        for (int p = 0; p < 8; p++)
        begin
            write_k(k_plan[p]);
            send_idle_pct = idle_plan[p % 4];
            recv_stall_pct = stall_plan[p % 4];
            random_phase(170, p == 0 || p == 5);
            drain();
        end

        if (error_count == 0)
            $display("[knn_topk_distance_select] OK");
        else
            $display("[knn_topk_distance_select] ERROR");
        $finish;
    end

endmodule
